// ----- hw/rtl/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types, codes and helpers of the segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int ADDR_W = 48;   // absolute address width
  localparam int FLD_W  = 17;   // size and counter field width
  localparam int RSZ_W  = 18;   // rounded size width

  localparam logic [FLD_W-1:0] USED_CAP = 17'h1FFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_GROW  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  localparam logic CFG_ARENA_BASE = 1'b0;
  localparam logic CFG_ARENA_SIZE = 1'b1;

  // (n + 7) & -8, zero goes to 8
  function automatic logic [RSZ_W-1:0] round8(input logic [FLD_W-1:0] n);
    logic [RSZ_W-1:0] r;
    r = ({1'b0, n} + RSZ_W'(7)) & ~RSZ_W'(7);
    return (r == '0) ? RSZ_W'(8) : r;
  endfunction

endpackage

// ----- hw/rtl/sfla_if.sv -----
// ----------------------------------------------------------------------------
// sfla_if
// Request and response channels of the allocator (valid/ready).
// ----------------------------------------------------------------------------
interface sfla_req_if;
  import sfla_pkg::*;
  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  logic [FLD_W-1:0]     req_size;
  logic [FLD_W-1:0]     old_size;
  logic [ADDR_W-1:0]    block_addr;
  modport source (output valid, cmd, req_size, old_size, block_addr, input ready);
  modport sink   (input valid, cmd, req_size, old_size, block_addr, output ready);
endinterface

interface sfla_rsp_if;
  import sfla_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    result_addr;
  logic [1:0]           status;
  logic [FLD_W-1:0]     bytes_in_use;
  logic [FLD_W-1:0]     peak_in_use;
  logic [FLD_W-1:0]     peak_top;
  modport source (output valid, result_addr, status, bytes_in_use, peak_in_use, peak_top,
                  input ready);
  modport sink   (input valid, result_addr, status, bytes_in_use, peak_in_use, peak_top,
                  output ready);
endinterface

// ----- hw/rtl/segregated_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_top
// Arena allocator: size-class free lists, bump pointer, best-fit piece table.
// ----------------------------------------------------------------------------
// Usage:
//  - in_req carries one request (allocate, free, grow, reset arena); every
//    request yields exactly one response on out_rsp.
//  - cfg_we/cfg_index/cfg_data write arena_base (0) and arena_size (1); write
//    them only while no request is in flight.
//  - Request time is set by the read-modify-write of the class-head and link
//    memories (registered reads) and by the piece-table scan of a large
//    allocate (scan one entry per cycle); a split remainder adds to it, and
//    a grow that cannot extend in place costs an allocate plus a free.
//  - Reset arena walks the class-head memory one entry a cycle, clearing
//    every entry, then responds.
//  - After rst_n the same clearing pass runs; in_req.ready stays low for it.
//  - One request is worked on at a time. A finished response waits in the
//    output register; the next request is accepted meanwhile and only its
//    own completion waits for out_rsp.ready.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_top #(
  parameter int ARENA_BYTES   = 65536,
  parameter int SMALL_LIMIT   = 16384,
  parameter int PIECE_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sfla_req_if.sink                  in_req,
  sfla_rsp_if.source                out_rsp,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sfla_pkg::ADDR_W-1:0] cfg_data
);
  import sfla_pkg::*;

  localparam int CLASS_COUNT = (SMALL_LIMIT + 7) / 8;
  localparam int CW  = $clog2(CLASS_COUNT);
  localparam int WORD_COUNT = (ARENA_BYTES + 7) / 8;
  localparam int WW  = $clog2(WORD_COUNT);
  localparam int LW  = $clog2(WORD_COUNT + 1);      // link: 0 end, else word + 1
  localparam int OW  = $clog2(ARENA_BYTES + 1);
  localparam int SW  = (OW > RSZ_W) ? OW : RSZ_W;   // internal size/offset width
  localparam int PIW = (PIECE_ENTRIES > 1) ? $clog2(PIECE_ENTRIES) : 1;
  localparam int PCW = $clog2(PIECE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_RDH, S_A_HEAD, S_A_LINK, S_SCAN, S_PICK,
    S_BUMP, S_ALLOC_OK, S_FREE, S_ADD, S_ADD_HEAD, S_FINISH
  } state_t;

  // ---------------- memories ----------------
  logic [LW-1:0]  heads_mem [CLASS_COUNT];
  logic [LW-1:0]  link_mem  [WORD_COUNT];
  logic [SW-1:0]  psize_mem [PIECE_ENTRIES];
  logic [SW-1:0]  poff_mem  [PIECE_ENTRIES];
  logic [15:0]    pord_mem  [PIECE_ENTRIES];

  logic           hd_we;
  logic [CW-1:0]  hd_waddr, hd_raddr;
  logic [LW-1:0]  hd_wdata, hd_rdata;
  logic           lk_we;
  logic [WW-1:0]  lk_waddr, lk_raddr;
  logic [LW-1:0]  lk_wdata, lk_rdata;
  logic           pc_we;
  logic [PIW-1:0] pc_waddr, pc_raddr;
  logic [SW-1:0]  pc_wsize, pc_woff, pc_rsize, pc_roff;
  logic [15:0]    pc_word, pc_rord;

  always_ff @(posedge clk) begin
    if (hd_we) heads_mem[hd_waddr] <= hd_wdata;
    hd_rdata <= heads_mem[hd_raddr];
  end

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    lk_rdata <= link_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      psize_mem[pc_waddr] <= pc_wsize;
      poff_mem[pc_waddr]  <= pc_woff;
      pord_mem[pc_waddr]  <= pc_word;
    end
    pc_rsize <= psize_mem[pc_raddr];
    pc_roff  <= poff_mem[pc_raddr];
    pc_rord  <= pord_mem[pc_raddr];
  end

  // ---------------- registers ----------------
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [FLD_W-1:0]    size_r;
  logic [SW-1:0]       bump_r, bump_nxt;
  logic [FLD_W-1:0]    used_r, used_nxt;
  logic [FLD_W-1:0]    peak_used_r, peak_used_nxt;
  logic [SW-1:0]       peak_bump_r, peak_bump_nxt;
  logic [15:0]         stamp_r, stamp_nxt;
  logic [PIECE_ENTRIES-1:0] pvalid_r, pvalid_nxt;
  logic [CW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_fin_r, clr_fin_nxt;   // respond after the clear

  // request latch
  cmd_t                cmd_r, cmd_nxt;
  logic [SW-1:0]       rn_r, rn_nxt, ro_r, ro_nxt;
  logic [ADDR_W-1:0]   boff_r, boff_nxt, addr_r, addr_nxt;
  logic                le_r, le_nxt;              // req_size <= old_size

  // work registers
  logic [SW-1:0]       off_r, off_nxt;
  logic [ADDR_W-1:0]   res_r, res_nxt;
  status_t             st_r, st_nxt;
  logic [SW-1:0]       ab_off_r, ab_off_nxt, ab_size_r, ab_size_nxt;
  logic                ret_alloc_r, ret_alloc_nxt; // add_block return target

  // scan
  logic [PCW-1:0]      scan_idx_r, scan_idx_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [PIW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                best_v_r, best_v_nxt;
  logic [PIW-1:0]      best_idx_r, best_idx_nxt;
  logic [SW-1:0]       best_size_r, best_size_nxt, best_off_r, best_off_nxt;
  logic [15:0]         best_age_r, best_age_nxt;

  // output register
  logic                out_v_r, out_v_nxt;
  logic [ADDR_W-1:0]   o_addr_r, o_addr_nxt;
  status_t             o_st_r, o_st_nxt;
  logic [FLD_W-1:0]    o_used_r, o_used_nxt, o_peak_r, o_peak_nxt, o_top_r, o_top_nxt;

  // ---------------- helpers ----------------
  logic [SW-1:0]  end_w, sz_ext;
  logic           accept;
  logic [PIW-1:0] slot;
  logic           slot_found;

  assign accept = in_req.valid && in_req.ready;
  assign sz_ext = SW'(size_r);
  assign end_w  = ((sz_ext > SW'(ARENA_BYTES)) ? SW'(ARENA_BYTES) : sz_ext) & ~SW'(7);

  // first invalid piece slot
  always_comb begin
    slot = '0;
    slot_found = 1'b0;
    for (int i = PIECE_ENTRIES - 1; i >= 0; i--) begin
      if (!pvalid_r[i]) begin
        slot = PIW'(i);
        slot_found = 1'b1;
      end
    end
  end

  function automatic logic [FLD_W-1:0] sat_add(input logic [FLD_W-1:0] u,
                                               input logic [SW-1:0] n);
    logic [SW:0] s;
    s = (SW+1)'(u) + (SW+1)'(n);
    return (s > (SW+1)'(USED_CAP)) ? USED_CAP : s[FLD_W-1:0];
  endfunction

  always_comb begin
    logic [SW:0]     sum_w;
    logic [ADDR_W:0] bsum;
    logic [SW-1:0]   add_w;
    logic [LW:0]     hm1;
    logic [15:0]     age;
    logic            take;

    state_nxt = state_r;
    bump_nxt = bump_r;  used_nxt = used_r;
    peak_used_nxt = peak_used_r;  peak_bump_nxt = peak_bump_r;
    stamp_nxt = stamp_r;  pvalid_nxt = pvalid_r;
    clr_cnt_nxt = clr_cnt_r;  clr_fin_nxt = clr_fin_r;
    cmd_nxt = cmd_r;  rn_nxt = rn_r;  ro_nxt = ro_r;
    boff_nxt = boff_r;  addr_nxt = addr_r;  le_nxt = le_r;
    off_nxt = off_r;  res_nxt = res_r;  st_nxt = st_r;
    ab_off_nxt = ab_off_r;  ab_size_nxt = ab_size_r;  ret_alloc_nxt = ret_alloc_r;
    scan_idx_nxt = scan_idx_r;  cmp_v_nxt = 1'b0;  cmp_idx_nxt = cmp_idx_r;
    best_v_nxt = best_v_r;  best_idx_nxt = best_idx_r;
    best_size_nxt = best_size_r;  best_off_nxt = best_off_r;  best_age_nxt = best_age_r;
    out_v_nxt = out_v_r;  o_addr_nxt = o_addr_r;  o_st_nxt = o_st_r;
    o_used_nxt = o_used_r;  o_peak_nxt = o_peak_r;  o_top_nxt = o_top_r;

    hd_we = 1'b0;  hd_waddr = '0;  hd_wdata = '0;  hd_raddr = '0;
    lk_we = 1'b0;  lk_waddr = '0;  lk_wdata = '0;  lk_raddr = '0;
    pc_we = 1'b0;  pc_waddr = slot;  pc_wsize = ab_size_r;  pc_woff = ab_off_r;
    pc_word = stamp_r;  pc_raddr = scan_idx_r[PIW-1:0];

    sum_w = '0;  bsum = '0;  add_w = '0;  hm1 = '0;  age = '0;  take = 1'b0;

    if (out_v_r && out_rsp.ready) out_v_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        hd_we = 1'b1;  hd_waddr = clr_cnt_r;  hd_wdata = '0;
        pvalid_nxt = '0;  stamp_nxt = '0;  bump_nxt = '0;
        used_nxt = '0;  peak_used_nxt = '0;  peak_bump_nxt = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CW'(CLASS_COUNT - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt = clr_fin_r ? S_FINISH : S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_req.cmd;
          rn_nxt   = SW'(round8(in_req.req_size));
          ro_nxt   = SW'(round8(in_req.old_size));
          boff_nxt = in_req.block_addr - base_r;
          addr_nxt = in_req.block_addr;
          le_nxt   = (in_req.req_size <= in_req.old_size);
          res_nxt  = '0;
          st_nxt   = ST_OK;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        scan_idx_nxt = '0;  best_v_nxt = 1'b0;
        case (cmd_r)
          CMD_ALLOC: state_nxt = (rn_r < SW'(SMALL_LIMIT)) ? S_A_RDH : S_SCAN;
          CMD_FREE:  state_nxt = S_FREE;
          CMD_GROW: begin
            bsum  = {1'b0, boff_r} + (ADDR_W+1)'(ro_r);
            add_w = rn_r - ro_r;
            if (le_r) begin
              res_nxt = addr_r;
              state_nxt = S_FINISH;
            end else if (bsum == (ADDR_W+1)'(bump_r) && bump_r <= end_w &&
                         (end_w - bump_r) >= add_w) begin
              bump_nxt = bump_r + add_w;
              used_nxt = sat_add(used_r, add_w);
              if (used_nxt > peak_used_r) peak_used_nxt = used_nxt;
              if (bump_nxt > peak_bump_r) peak_bump_nxt = bump_nxt;
              res_nxt = addr_r;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = (rn_r < SW'(SMALL_LIMIT)) ? S_A_RDH : S_SCAN;
            end
          end
          default: begin   // reset arena
            clr_cnt_nxt = '0;
            clr_fin_nxt = 1'b1;
            state_nxt = S_CLEAR;
          end
        endcase
      end

      // small allocate: head read, then link read, then head write-back
      S_A_RDH: begin
        hd_raddr = rn_r[CW+2:3];
        state_nxt = S_A_HEAD;
      end

      S_A_HEAD: begin
        hm1 = {1'b0, hd_rdata} - (LW+1)'(1);
        if (hd_rdata != '0 && hm1 < (LW+1)'(WORD_COUNT)) begin
          off_nxt  = SW'(hm1) << 3;
          lk_raddr = hm1[WW-1:0];
          state_nxt = S_A_LINK;
        end else begin
          state_nxt = S_BUMP;
        end
      end

      S_A_LINK: begin
        hd_we = 1'b1;  hd_waddr = rn_r[CW+2:3];  hd_wdata = lk_rdata;
        state_nxt = S_ALLOC_OK;
      end

      // best-fit scan, one entry per cycle, read data compared in the cycle after its read
      S_SCAN: begin
        if (scan_idx_r != PCW'(PIECE_ENTRIES)) begin
          cmp_v_nxt = 1'b1;
          cmp_idx_nxt = scan_idx_r[PIW-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (cmp_v_r && pvalid_r[cmp_idx_r] && pc_rsize >= rn_r) begin
          age = stamp_r - pc_rord;
          if (!best_v_r || pc_rsize < best_size_r) take = 1'b1;
          else if (pc_rsize == best_size_r && age > best_age_r) take = 1'b1;
          if (take) begin
            best_v_nxt = 1'b1;  best_idx_nxt = cmp_idx_r;
            best_size_nxt = pc_rsize;  best_off_nxt = pc_roff;  best_age_nxt = age;
          end
        end
        if (!cmp_v_r && scan_idx_r == PCW'(PIECE_ENTRIES)) state_nxt = S_PICK;
      end

      S_PICK: begin
        if (!best_v_r) begin
          state_nxt = S_BUMP;
        end else begin
          off_nxt = best_off_r;
          pvalid_nxt[best_idx_r] = 1'b0;
          if (best_size_r != rn_r) begin
            ab_off_nxt = best_off_r + rn_r;
            ab_size_nxt = best_size_r - rn_r;
            ret_alloc_nxt = 1'b1;
            state_nxt = S_ADD;
          end else begin
            state_nxt = S_ALLOC_OK;
          end
        end
      end

      S_BUMP: begin
        if (bump_r > end_w || (end_w - bump_r) < rn_r) begin
          st_nxt = ST_NOSPACE;
          res_nxt = '0;
          state_nxt = S_FINISH;
        end else begin
          off_nxt = bump_r;
          bump_nxt = bump_r + rn_r;
          state_nxt = S_ALLOC_OK;
        end
      end

      S_ALLOC_OK: begin
        used_nxt = sat_add(used_r, rn_r);
        if (used_nxt > peak_used_r) peak_used_nxt = used_nxt;
        if (bump_r > peak_bump_r) peak_bump_nxt = bump_r;
        res_nxt = base_r + ADDR_W'(off_r);
        state_nxt = (cmd_r == CMD_GROW) ? S_FREE : S_FINISH;
      end

      S_FREE: begin
        bsum = {1'b0, boff_r} + (ADDR_W+1)'(ro_r);
        if (boff_r[2:0] != 3'd0 || bsum > (ADDR_W+1)'(end_w)) begin
          state_nxt = S_FINISH;   // bad free: ignored
        end else begin
          used_nxt = (SW'(used_r) > ro_r) ? (used_r - ro_r[FLD_W-1:0]) : '0;
          ab_off_nxt = boff_r[SW-1:0];
          ab_size_nxt = ro_r;
          ret_alloc_nxt = 1'b0;
          state_nxt = S_ADD;
        end
      end

      // give a block back: top merge, class list push or piece insert
      S_ADD: begin
        sum_w = (SW+1)'(ab_off_r) + (SW+1)'(ab_size_r);
        if (sum_w == (SW+1)'(bump_r)) begin
          bump_nxt = ab_off_r;
          state_nxt = ret_alloc_r ? S_ALLOC_OK : S_FINISH;
        end else if (ab_size_r < SW'(SMALL_LIMIT)) begin
          if ((ab_off_r >> 3) >= SW'(WORD_COUNT)) begin
            state_nxt = ret_alloc_r ? S_ALLOC_OK : S_FINISH;
          end else begin
            hd_raddr = ab_size_r[CW+2:3];
            state_nxt = S_ADD_HEAD;
          end
        end else begin
          if (slot_found) begin
            pc_we = 1'b1;
            pvalid_nxt[slot] = 1'b1;
            stamp_nxt = stamp_r + 16'd1;
          end else begin
            st_nxt = ST_DROPPED;
          end
          state_nxt = ret_alloc_r ? S_ALLOC_OK : S_FINISH;
        end
      end

      S_ADD_HEAD: begin
        lk_we = 1'b1;  lk_waddr = ab_off_r[WW+2:3];  lk_wdata = hd_rdata;
        hd_we = 1'b1;  hd_waddr = ab_size_r[CW+2:3];
        hd_wdata = LW'(ab_off_r[WW+2:3]) + LW'(1);
        state_nxt = ret_alloc_r ? S_ALLOC_OK : S_FINISH;
      end

      S_FINISH: begin
        if (!out_v_r || out_rsp.ready) begin
          out_v_nxt = 1'b1;
          o_addr_nxt = res_r;  o_st_nxt = st_r;
          o_used_nxt = used_r;  o_peak_nxt = peak_used_r;
          o_top_nxt = peak_bump_r[FLD_W-1:0];
          clr_fin_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      base_r <= '0;
      size_r <= 17'd65536;
      bump_r <= '0;  used_r <= '0;  peak_used_r <= '0;  peak_bump_r <= '0;
      stamp_r <= '0;  pvalid_r <= '0;
      clr_cnt_r <= '0;  clr_fin_r <= 1'b0;
      scan_idx_r <= '0;  cmp_v_r <= 1'b0;  best_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bump_r <= bump_nxt;  used_r <= used_nxt;
      peak_used_r <= peak_used_nxt;  peak_bump_r <= peak_bump_nxt;
      stamp_r <= stamp_nxt;  pvalid_r <= pvalid_nxt;
      clr_cnt_r <= clr_cnt_nxt;  clr_fin_r <= clr_fin_nxt;
      scan_idx_r <= scan_idx_nxt;  cmp_v_r <= cmp_v_nxt;  best_v_r <= best_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ARENA_BASE: base_r <= cfg_data;
          CFG_ARENA_SIZE: size_r <= cfg_data[FLD_W-1:0];
          default: ;
        endcase
      end
    end
    // payload, no reset
    cmd_r <= cmd_nxt;  rn_r <= rn_nxt;  ro_r <= ro_nxt;
    boff_r <= boff_nxt;  addr_r <= addr_nxt;  le_r <= le_nxt;
    off_r <= off_nxt;  res_r <= res_nxt;  st_r <= st_nxt;
    ab_off_r <= ab_off_nxt;  ab_size_r <= ab_size_nxt;  ret_alloc_r <= ret_alloc_nxt;
    cmp_idx_r <= cmp_idx_nxt;  best_idx_r <= best_idx_nxt;
    best_size_r <= best_size_nxt;  best_off_r <= best_off_nxt;  best_age_r <= best_age_nxt;
    o_addr_r <= o_addr_nxt;  o_st_r <= o_st_nxt;
    o_used_r <= o_used_nxt;  o_peak_r <= o_peak_nxt;  o_top_r <= o_top_nxt;
  end

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_v_r;
  assign out_rsp.result_addr  = o_addr_r;
  assign out_rsp.status       = o_st_r;
  assign out_rsp.bytes_in_use = o_used_r;
  assign out_rsp.peak_in_use  = o_peak_r;
  assign out_rsp.peak_top     = o_top_r;

  // ---------------- assertions ----------------
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DISPATCH)
    else $error("accepted request not dispatched");

  a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    peak_used_r >= used_r)
    else $error("peak_in_use below bytes_in_use");

  a_clear_pieces: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |=> pvalid_r == '0)
    else $error("piece table not cleared");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= PCW'(PIECE_ENTRIES))
    else $error("piece scan index out of range");

endmodule

// ----- dv/sfla_checker.sv -----
// ----------------------------------------------------------------------------
// sfla_checker
// Watches the request, response and config ports of the allocator, keeps its
// own copy of the arena state, predicts every response and compares it.
// ----------------------------------------------------------------------------
module sfla_checker
  import sfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sfla_req_if               req,
  sfla_rsp_if               rsp,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  output int                failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ARENA_MAX = 65536;
  localparam int unsigned SMALL_MAX = 16384;
  localparam int unsigned PIECES    = 16;
  localparam int unsigned CLASSES   = SMALL_MAX / 8;
  localparam int unsigned WORDS     = ARENA_MAX / 8;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           st;
    logic [FLD_W-1:0]  used;
    logic [FLD_W-1:0]  peak;
    logic [FLD_W-1:0]  top;
  } grant_t;

  grant_t grants_due[$];
  int     mismatch_count = 0;

  logic [ADDR_W-1:0] base_q;
  int unsigned size_q, top_off, stamp, used_b, peak_u, peak_b;
  int unsigned heads [CLASSES];
  int unsigned links [WORDS];
  int unsigned psize [PIECES];
  int unsigned poff  [PIECES];
  int unsigned porder[PIECES];
  bit          pval  [PIECES];

  function automatic int unsigned rnd8(longint unsigned n);
    longint unsigned r;
    r = (n + 7) & ~64'd7;
    return (r == 0) ? 8 : int'(r);
  endfunction

  function automatic int unsigned arena_limit();
    int unsigned e;
    e = (size_q > ARENA_MAX) ? ARENA_MAX : size_q;
    return e & ~32'd7;
  endfunction

  function automatic void wipe_arena();
    top_off = 0; stamp = 0; used_b = 0; peak_u = 0; peak_b = 0;
    foreach (heads[i]) heads[i] = 0;
    foreach (pval[i]) pval[i] = 0;
  endfunction

  function automatic bit bump_grab(int unsigned n, output int unsigned off);
    int unsigned e;
    e = arena_limit();
    off = 0;
    if (top_off > e || e - top_off < n) return 0;
    off = top_off;
    top_off += n;
    return 1;
  endfunction

  // returns ST_DROPPED when the piece table has no room
  function automatic status_t give_back(int unsigned off, int unsigned sz);
    longint unsigned w;
    if (longint'(off) + sz == top_off) begin
      top_off = off;
      return ST_OK;
    end
    if (sz < SMALL_MAX) begin
      w = off >> 3;
      if ((sz >> 3) >= CLASSES || w >= WORDS) return ST_OK;
      links[w] = heads[sz >> 3];
      heads[sz >> 3] = w + 1;
      return ST_OK;
    end
    for (int i = 0; i < PIECES; i++) begin
      if (!pval[i]) begin
        pval[i] = 1; psize[i] = sz; poff[i] = off; porder[i] = stamp;
        stamp = (stamp + 1) & 16'hFFFF;
        return ST_OK;
      end
    end
    return ST_DROPPED;
  endfunction

  function automatic void bump_stats(int unsigned n);
    longint unsigned u;
    u = longint'(used_b) + n;
    used_b = (u > USED_CAP) ? USED_CAP : int'(u);
    if (used_b > peak_u) peak_u = used_b;
    if (top_off > peak_b) peak_b = top_off;
  endfunction

  function automatic bit take_block(int unsigned n, output int unsigned off,
                                    inout status_t st);
    int best;
    int unsigned h, left, ai, ab;
    bit ok;
    best = -1;
    off = 0;
    if (n < SMALL_MAX) begin
      h = heads[n >> 3];
      if (h != 0 && h - 1 < WORDS) begin
        off = (h - 1) << 3;
        heads[n >> 3] = links[h - 1];
        ok = 1;
      end else ok = bump_grab(n, off);
    end else begin
      for (int i = 0; i < PIECES; i++) begin
        if (!pval[i] || psize[i] < n) continue;
        if (best < 0 || psize[i] < psize[best]) best = i;
        else if (psize[i] == psize[best]) begin
          ai = (stamp - porder[i]) & 16'hFFFF;
          ab = (stamp - porder[best]) & 16'hFFFF;
          if (ai > ab) best = i;
        end
      end
      if (best < 0) ok = bump_grab(n, off);
      else begin
        left = psize[best] - n;
        off = poff[best];
        pval[best] = 0;
        ok = 1;
        if (left != 0 && give_back(off + n, left) == ST_DROPPED) st = ST_DROPPED;
      end
    end
    if (ok) bump_stats(n);
    return ok;
  endfunction

  function automatic void release_block(logic [ADDR_W-1:0] addr, logic [FLD_W-1:0] sz,
                                        inout status_t st);
    logic [ADDR_W-1:0] off;
    int unsigned n;
    off = addr - base_q;
    n = rnd8(sz);
    if (off[2:0] != 0 || longint'(off) + n > arena_limit()) return;
    used_b = (used_b > n) ? used_b - n : 0;
    if (give_back(int'(off), n) == ST_DROPPED) st = ST_DROPPED;
  endfunction

  function automatic grant_t predict_grant(cmd_t c, logic [FLD_W-1:0] rq,
                                           logic [FLD_W-1:0] od, logic [ADDR_W-1:0] ad);
    grant_t g;
    int unsigned off, ro, rn, e;
    logic [ADDR_W-1:0] boff;
    g.addr = '0;
    g.st = ST_OK;
    case (c)
      CMD_ALLOC: begin
        if (take_block(rnd8(rq), off, g.st)) g.addr = base_q + off;
        else g.st = ST_NOSPACE;
      end
      CMD_FREE: release_block(ad, od, g.st);
      CMD_GROW: begin
        if (rq <= od) g.addr = ad;
        else begin
          boff = ad - base_q;
          ro = rnd8(od);
          rn = rnd8(rq);
          e = arena_limit();
          if (longint'(boff) + ro == top_off && top_off <= e && e - top_off >= rn - ro) begin
            top_off += rn - ro;
            bump_stats(rn - ro);
            g.addr = ad;
          end else if (take_block(rn, off, g.st)) begin
            g.addr = base_q + off;
            release_block(ad, od, g.st);
          end else g.st = ST_NOSPACE;
        end
      end
      default: wipe_arena();
    endcase
    g.used = used_b;
    g.peak = peak_u;
    g.top  = peak_b;
    return g;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("%0t sfla_checker: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      base_q = '0;
      size_q = 65536;
      wipe_arena();
      grants_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ARENA_BASE) base_q = cfg_data;
        else size_q = cfg_data[FLD_W-1:0];
      end
      // response checked before the request of the same edge is predicted
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) report("unexpected response", rsp.result_addr, 0);
        else begin
          want = grants_due.pop_front();
          if (rsp.result_addr !== want.addr) report("result_addr", rsp.result_addr, want.addr);
          if (rsp.status !== want.st) report("status", rsp.status, want.st);
          if (rsp.bytes_in_use !== want.used) report("bytes_in_use", rsp.bytes_in_use, want.used);
          if (rsp.peak_in_use !== want.peak) report("peak_in_use", rsp.peak_in_use, want.peak);
          if (rsp.peak_top !== want.top) report("peak_top", rsp.peak_top, want.top);
        end
      end
      if (req.valid && req.ready)
        grants_due.push_back(predict_grant(req.cmd, req.req_size, req.old_size,
                                           req.block_addr));
    end
    failures <= mismatch_count + grants_due.size();
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the allocator testbench: drives requests, config writes and response
// back-pressure; a checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module tb;
  import sfla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HOLD_CYCLES     = 300;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [FLD_W-1:0]  size;
  } live_t;

  typedef struct {
    cmd_t             c;
    bit               tracked;
    live_t            blk;
    logic [FLD_W-1:0] rq;
  } flight_t;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic              cfg_index = CFG_ARENA_BASE;
  logic [ADDR_W-1:0] cfg_data = '0;
  int                failures;

  sfla_req_if req_ch();
  sfla_rsp_if rsp_ch();

  segregated_free_list_allocator_top dut (
    .clk, .rst_n, .in_req(req_ch), .out_rsp(rsp_ch), .cfg_we, .cfg_index, .cfg_data
  );

  sfla_checker chk (
    .clk, .rst_n, .req(req_ch), .rsp(rsp_ch), .cfg_we, .cfg_index, .cfg_data, .failures
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // blocks the stimulus believes are live, and requests awaiting a response
  live_t   live_blocks[$];
  flight_t in_flight[$];
  logic [ADDR_W-1:0] cur_base;
  bit      quiet = 0;        // no idling on either side
  bit      hold_pending = 0; // asks the receiver for one long stall

  initial begin
    req_ch.valid = 0;
    req_ch.cmd = CMD_ALLOC;
    req_ch.req_size = '0;
    req_ch.old_size = '0;
    req_ch.block_addr = '0;
    rsp_ch.ready = 0;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        rsp_ch.ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1;
      end
    end
  end

  // track grants so frees and grows can target real blocks
  always @(posedge clk) begin
    flight_t f;
    if (rst_n && rsp_ch.valid && rsp_ch.ready && in_flight.size() != 0) begin
      f = in_flight.pop_front();
      if (f.tracked) begin
        if (f.c == CMD_ALLOC) begin
          if (rsp_ch.status != ST_NOSPACE) live_blocks.push_back('{rsp_ch.result_addr, f.rq});
        end else if (f.c == CMD_GROW) begin
          if (rsp_ch.status == ST_NOSPACE || f.rq <= f.blk.size) live_blocks.push_back(f.blk);
          else live_blocks.push_back('{rsp_ch.result_addr, f.rq});
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic issue(cmd_t c, logic [FLD_W-1:0] rq, logic [FLD_W-1:0] od,
                       logic [ADDR_W-1:0] ad, bit tracked = 0, live_t blk = '{0, 0});
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.cmd <= c;
    req_ch.req_size <= rq;
    req_ch.old_size <= od;
    req_ch.block_addr <= ad;
    do @(posedge clk); while (!req_ch.ready);
    in_flight.push_back('{c, tracked, blk, rq});
    if (c == CMD_CLEAR) live_blocks.delete();
  endtask

  // sender waits until every response has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 0;
    while (in_flight.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic new_setting(logic [ADDR_W-1:0] b, logic [FLD_W-1:0] sz);
    drain();
    write_reg(CFG_ARENA_BASE, b);
    write_reg(CFG_ARENA_SIZE, sz);
    cur_base = b;
    issue(CMD_CLEAR, '0, '0, '0);
  endtask

  function automatic logic [FLD_W-1:0] pick_size();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return $urandom_range(0, 600);
    if (p < 8) return $urandom_range(0, 16383);
    if (p < 9) return $urandom_range(16384, 40000);
    return $urandom_range(40000, 65536);
  endfunction

  task automatic random_request();
    int r, k;
    live_t b;
    logic [FLD_W-1:0] nsz;
    logic [ADDR_W-1:0] ad;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (live_blocks.size() == 0 && r >= 45 && r < 85) r = 0;
    if (r < 45) begin
      nsz = pick_size();
      issue(CMD_ALLOC, nsz, '0, '0, 1);
    end else if (r < 70) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[k];
      live_blocks.delete(k);
      issue(CMD_FREE, '0, b.size, b.addr);
    end else if (r < 85) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[k];
      live_blocks.delete(k);
      if ($urandom_range(0, 3) == 0) nsz = $urandom_range(0, b.size);
      else if (b.size > 63536) nsz = 65536;
      else nsz = b.size + $urandom_range(1, 2000);
      issue(CMD_GROW, nsz, b.size, b.addr, 1, b);
    end else begin
      // noise: arbitrary fields, frees and grows of unknown blocks
      c = cmd_t'($urandom_range(0, 2));
      if ($urandom_range(0, 149) == 0) c = CMD_CLEAR;
      if ($urandom_range(0, 1) == 0) ad = {$urandom, $urandom};
      else ad = cur_base + ($urandom_range(0, 65535) & ~32'd7);
      issue(c, $urandom_range(0, 65536), $urandom_range(0, 65536), ad);
    end
  endtask

  initial begin
    cur_base = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // default arena, directed corner requests
    new_setting('0, 65536);
    issue(CMD_ALLOC, 0, 0, 0);                         // zero size rounds to 8
    issue(CMD_ALLOC, 65536, 0, 0);                     // larger than what is left
    issue(CMD_ALLOC, 20000, 0, 0);                     // large from bump
    issue(CMD_FREE, 0, 8, 48'h3);                      // unaligned: ignored
    issue(CMD_FREE, 0, 65536, 48'h8);                  // runs past arena end: ignored
    repeat (17) issue(CMD_FREE, 0, 16384, 48'h0);      // overlapping pieces fill the table
    issue(CMD_ALLOC, 16384, 0, 0);                     // best fit from piece table
    issue(CMD_GROW, 100, 200, 48'h10);                 // not larger: unchanged
    issue(CMD_ALLOC, 16, 0, 0);
    issue(CMD_GROW, 64, 16, 48'h4E28);                 // grows in place at the top
    issue(CMD_ALLOC, 17'h1FFFF, 0, 0);                 // all size bits set
    issue(CMD_FREE, 0, 0, 48'h8);                      // zero size free
    issue(CMD_CLEAR, 0, 0, 0);
    for (int i = 0; i < 130; i++) begin
      if (i == 60) drain();
      random_request();
    end

    // base near the top of the address space: addresses wrap
    new_setting(48'hFFFF_FFFF_FF00, 65536);
    for (int i = 0; i < 140; i++) begin
      if (i == 30) hold_pending = 1;
      random_request();
    end

    // eight-byte arena, the smallest that is not empty
    new_setting({$urandom, $urandom}, 8);
    for (int i = 0; i < 40; i++) random_request();

    // random base and odd arena size
    new_setting({$urandom, $urandom} & ~48'h7, $urandom_range(1024, 65535));
    for (int i = 0; i < 120; i++) random_request();

    // back to the full arena; the tail runs with no idling
    new_setting(48'h0, 65536);
    for (int i = 0; i < 120; i++) begin
      if (i == 60) quiet = 1;
      random_request();
    end

    drain();
    repeat (20) @(posedge clk);
    if (failures == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sfla_pkg.sv
hw/rtl/sfla_if.sv
hw/rtl/segregated_free_list_allocator_top.sv
dv/sfla_checker.sv
dv/tb.sv
